/* rtl/core/e2bmw_pkg.sv */
package e2bmw_pkg;

  // words per indirect block are 256 << block size code
  localparam int unsigned BaseLog = 8;
  localparam logic [2:0] MaxLog = 3'd6;

  typedef enum logic [1:0] {
    REQ_LOAD_PTR     = 2'd0,
    REQ_LOAD_SECTORS = 2'd1,
    REQ_LOOKUP       = 2'd2,
    REQ_READ_RESP    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_ZERO_PTR   = 2'd1,
    STAT_PAST_END   = 2'd2,
    STAT_PAST_REACH = 2'd3
  } status_e;

  typedef enum logic {
    RES_READ_REQ = 1'b0,
    RES_DONE     = 1'b1
  } res_kind_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_WALK
  } state_e;

  typedef struct packed {
    status_e     status;
    logic [31:0] phys_block;
    logic [13:0] read_index;
    logic [31:0] read_block;
  } result_t;

  typedef struct packed {
    res_kind_e kind;
    result_t   res;
  } out_t;

  function automatic out_t mk_done(logic [31:0] phys, status_e st);
    out_t o;
    o.kind = RES_DONE;
    o.res.read_block = 32'd0;
    o.res.read_index = 14'd0;
    o.res.phys_block = (st == STAT_OK) ? phys : 32'd0;
    o.res.status = st;
    return o;
  endfunction

  function automatic out_t mk_req(logic [31:0] blk, logic [13:0] idx);
    out_t o;
    o.kind = RES_READ_REQ;
    o.res.read_block = blk;
    o.res.read_index = idx;
    o.res.phys_block = 32'd0;
    o.res.status = STAT_OK;
    return o;
  endfunction

  // bit offset of the index digit for a given remaining level
  function automatic logic [4:0] level_shift(logic [1:0] lvl, logic [3:0] s);
    logic [4:0] sh;
    case (lvl)
      2'd0: sh = 5'd0;
      2'd1: sh = {1'b0, s};
      default: sh = {s, 1'b0};
    endcase
    return sh;
  endfunction

endpackage

/* rtl/core/ext2_block_map_walker_unit.sv */
// ext2 block map walker: maps a file's logical block to a physical block through
// the inode's direct pointers and single/double/triple indirect arrays. In a
// lookup the pointer table is a synchronous memory, so the chosen slot is read
// in the accept cycle and decoded in the next one, when no new request is taken.
// Each indirect level then costs one word-read request out and one read response
// back; the round trip time is set by the memory outside. Non-response requests
// arriving during a walk are accepted and dropped. The table carries one valid bit
// per slot, so it reads as zero after reset with no clearing pass.
module ext2_block_map_walker_unit #(
  parameter int DIRECT_SLOTS  = 12,
  parameter int POINTER_SLOTS = 15
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_wdata_i,    // block size code
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // slot[3:0], pointer_value[35:4], sector_cnt[67:36], logical_block[99:68],
  // read_word[131:100], zero pad[135:132]
  input  logic [135:0] s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,   // req_type
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // rd_block[31:0], read_index[45:32], phys_block[77:46], status[79:78]
  output logic [79:0]  m_axis_tdata,
  output logic         m_axis_tuser    // result_kind
);

  localparam int AW = $clog2(POINTER_SLOTS);
  localparam logic [4:0] PointerSlots = 5'(POINTER_SLOTS);
  localparam logic [3:0] DirectSlots = 4'(DIRECT_SLOTS);
  localparam int ReachW = 44;

  // request fields
  e2bmw_pkg::req_e req;
  logic [3:0]  slot;
  logic [31:0] pointer_value, sector_cnt, logical_block, read_word;

  assign req           = e2bmw_pkg::req_e'(s_axis_tuser);
  assign slot          = s_axis_tdata[3:0];
  assign pointer_value = s_axis_tdata[35:4];
  assign sector_cnt    = s_axis_tdata[67:36];
  assign logical_block = s_axis_tdata[99:68];
  assign read_word     = s_axis_tdata[131:100];

  logic [2:0]  lbs_q;
  logic [31:0] sectors_q, sectors_d;
  logic [31:0] mem_q [POINTER_SLOTS];
  logic [POINTER_SLOTS-1:0] vld_q;
  logic [31:0] rd_data_q;
  logic        rd_ok_q;
  logic        rd_en, wr_en;

  e2bmw_pkg::state_e state_q, state_d;
  logic [1:0]  levels_q, levels_d;
  logic [31:0] resid_q, resid_d;
  logic        lk_early_q, lk_early_d;
  logic        lk_direct_q, lk_direct_d;
  e2bmw_pkg::status_e lk_status_q, lk_status_d;

  logic               out_valid_q, out_valid_d;
  e2bmw_pkg::out_t    out_q, out_d;

  logic s_acc;

  // block geometry
  logic [2:0]  eff_log;
  logic [3:0]  shift_s;
  logic [14:0] p15, mask15;
  logic [13:0] idx_mask;

  assign eff_log  = (lbs_q > e2bmw_pkg::MaxLog) ? e2bmw_pkg::MaxLog : lbs_q;
  assign shift_s  = 4'(e2bmw_pkg::BaseLog) + {1'b0, eff_log};
  assign p15      = 15'd1 << shift_s;
  assign mask15   = p15 - 15'd1;
  assign idx_mask = mask15[13:0];

  // lookup decode, done in the accept cycle
  logic [31:0] count, r;
  logic        past_end, is_direct, in_l0, in_l1, in_l2, in_table, slot_ok;
  logic [ReachW-1:0] re, p1, p2, p3, base, diff;
  logic [5:0]  sh3;
  logic [1:0]  level;
  logic [3:0]  root_slot, sel_slot;
  logic [AW-1:0] rd_addr;

  assign count     = sectors_q >> ({1'b0, eff_log} + 4'd1);
  assign past_end  = logical_block >= count;
  assign is_direct = logical_block < 32'(DIRECT_SLOTS);
  assign r         = logical_block - 32'(DIRECT_SLOTS);
  assign re        = {12'd0, r};
  assign sh3       = {2'b00, shift_s} + {1'b0, shift_s, 1'b0};
  assign p1        = 44'd1 << shift_s;
  assign p2        = 44'd1 << {shift_s, 1'b0};
  assign p3        = 44'd1 << sh3;
  // the level limits have disjoint bits, so the running sums are plain ORs
  assign in_l0     = re < p1;
  assign in_l1     = re < (p1 | p2);
  assign in_l2     = re < (p1 | p2 | p3);
  assign level     = in_l0 ? 2'd0 : (in_l1 ? 2'd1 : 2'd2);
  assign base      = in_l0 ? '0 : (in_l1 ? p1 : (p1 | p2));
  assign diff      = re - base;
  assign root_slot = DirectSlots + {2'b00, level};
  assign sel_slot  = is_direct ? logical_block[3:0] : root_slot;
  assign in_table  = {1'b0, sel_slot} < PointerSlots;
  assign rd_addr   = sel_slot[AW-1:0];
  assign slot_ok   = {1'b0, slot} < PointerSlots;

  // index digits for the walk
  logic [4:0]  look_sh, walk_sh;
  logic [1:0]  levels_dec;
  logic [13:0] look_idx, walk_idx;

  assign levels_dec = levels_q - 2'd1;
  assign look_sh    = e2bmw_pkg::level_shift(levels_q, shift_s);
  assign walk_sh    = e2bmw_pkg::level_shift(levels_dec, shift_s);
  assign look_idx   = 14'(resid_q >> look_sh) & idx_mask;
  assign walk_idx   = 14'(resid_q >> walk_sh) & idx_mask;

  assign s_axis_tready = (state_q != e2bmw_pkg::S_LOOK) && (!out_valid_q || m_axis_tready);
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d     = state_q;
    levels_d    = levels_q;
    resid_d     = resid_q;
    lk_early_d  = lk_early_q;
    lk_direct_d = lk_direct_q;
    lk_status_d = lk_status_q;
    sectors_d   = sectors_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    case (state_q)
      e2bmw_pkg::S_IDLE: begin
        if (s_acc) begin
          case (req)
            e2bmw_pkg::REQ_LOAD_PTR: wr_en = slot_ok;
            e2bmw_pkg::REQ_LOAD_SECTORS: sectors_d = sector_cnt;
            e2bmw_pkg::REQ_LOOKUP: begin
              rd_en       = 1'b1;
              lk_early_d  = past_end || (!is_direct && !in_l2);
              lk_status_d = past_end ? e2bmw_pkg::STAT_PAST_END
                                     : e2bmw_pkg::STAT_PAST_REACH;
              lk_direct_d = is_direct;
              levels_d    = level;
              resid_d     = diff[31:0];
              state_d     = e2bmw_pkg::S_LOOK;
            end
            default: ;
          endcase
        end
      end
      e2bmw_pkg::S_LOOK: begin
        out_valid_d = 1'b1;
        state_d     = e2bmw_pkg::S_IDLE;
        if (lk_early_q) begin
          out_d = e2bmw_pkg::mk_done(32'd0, lk_status_q);
        end else if (!rd_ok_q || rd_data_q == 32'd0) begin
          out_d = e2bmw_pkg::mk_done(32'd0, e2bmw_pkg::STAT_ZERO_PTR);
        end else if (lk_direct_q) begin
          out_d = e2bmw_pkg::mk_done(rd_data_q, e2bmw_pkg::STAT_OK);
        end else begin
          out_d   = e2bmw_pkg::mk_req(rd_data_q, look_idx);
          state_d = e2bmw_pkg::S_WALK;
        end
      end
      e2bmw_pkg::S_WALK: begin
        if (s_acc && req == e2bmw_pkg::REQ_READ_RESP) begin
          out_valid_d = 1'b1;
          if (read_word == 32'd0) begin
            out_d   = e2bmw_pkg::mk_done(32'd0, e2bmw_pkg::STAT_ZERO_PTR);
            state_d = e2bmw_pkg::S_IDLE;
          end else if (levels_q == 2'd0) begin
            out_d   = e2bmw_pkg::mk_done(read_word, e2bmw_pkg::STAT_OK);
            state_d = e2bmw_pkg::S_IDLE;
          end else begin
            out_d    = e2bmw_pkg::mk_req(read_word, walk_idx);
            levels_d = levels_dec;
          end
        end
      end
      default: state_d = e2bmw_pkg::S_IDLE;
    endcase
  end

  // pointer table
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[slot[AW-1:0]] <= pointer_value;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      rd_ok_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[slot[AW-1:0]] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok_q <= in_table && vld_q[rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lbs_q       <= 3'd0;
      sectors_q   <= 32'd0;
      state_q     <= e2bmw_pkg::S_IDLE;
      levels_q    <= 2'd0;
      resid_q     <= 32'd0;
      lk_early_q  <= 1'b0;
      lk_direct_q <= 1'b0;
      lk_status_q <= e2bmw_pkg::STAT_OK;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        lbs_q <= cfg_wdata_i;
      end
      sectors_q   <= sectors_d;
      state_q     <= state_d;
      levels_q    <= levels_d;
      resid_q     <= resid_d;
      lk_early_q  <= lk_early_d;
      lk_direct_q <= lk_direct_d;
      lk_status_q <= lk_status_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.res;
  assign m_axis_tuser  = out_q.kind;

  // a lookup always moves to the decode cycle
  a_lookup_to_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == e2bmw_pkg::S_IDLE && s_acc && req == e2bmw_pkg::REQ_LOOKUP)
    |=> state_q == e2bmw_pkg::S_LOOK)
    else $error("lookup did not enter decode");

  // decode writes the output register, which must be free then
  a_look_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == e2bmw_pkg::S_LOOK |-> !out_valid_q)
    else $error("output busy during decode");

  // a response during a walk always yields a result
  a_resp_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == e2bmw_pkg::S_WALK && s_acc && req == e2bmw_pkg::REQ_READ_RESP)
    |=> out_valid_q)
    else $error("response produced no result");

  // at most two levels remain below the root
  a_levels_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == e2bmw_pkg::S_WALK |-> levels_q != 2'd3)
    else $error("walk level out of range");

  // a walk only starts from a read request
  a_walk_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == e2bmw_pkg::S_LOOK && state_d == e2bmw_pkg::S_WALK)
    |=> (out_valid_q && out_q.kind == e2bmw_pkg::RES_READ_REQ))
    else $error("walk entered without a read request");

endmodule
